/* sv/sks_pkg.sv */
// ----------------------------------------------------------------------------
// sks_pkg: shared types and constants for the SPI keyboard scancode slave
// Event and response transaction types, event codes, phase codes, commands.
// ----------------------------------------------------------------------------
package sks_pkg;

    localparam logic [1:0] OP_SELECT   = 2'd0;
    localparam logic [1:0] OP_DESELECT = 2'd1;
    localparam logic [1:0] OP_BYTE     = 2'd2;
    localparam logic [1:0] OP_READY    = 2'd3;

    localparam logic [6:0] CMD_RESET  = 7'h00;
    localparam logic [6:0] CMD_STATUS = 7'h01;

    localparam logic [7:0] RSP_ZERO  = 8'h00;
    localparam logic [7:0] RSP_EMPTY = 8'hFF;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'b00001,
        PH_NEW     = 5'b00010,
        PH_READ    = 5'b00100,
        PH_RESPOND = 5'b01000,
        PH_DONE    = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] mosi_byte;
        logic       ready_level;
        logic [7:0] scancode;
    } evt_t;

    typedef struct packed {
        logic [7:0] miso_byte;
        logic       miso_valid;
        logic       irq;
    } rsp_t;

endpackage

/* sv/spi_keyboard_scancode_slave.sv */
// A response transaction is registered into the response buffer when its event is accepted.
// Throughput: one event per cycle while evt_stall is low; the response buffer holds two transactions.
// Event stall rises only when both buffer entries wait on a stalled output.
// Reset: rst_n clears phase to idle, the held scancode, the full flag and the buffer.
// ----------------------------------------------------------------------------
// spi_keyboard_scancode_slave: SPI slave holding one keyboard scancode
// Event decoder with state registers feeding a registered response buffer.
// ----------------------------------------------------------------------------
module spi_keyboard_scancode_slave
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          evt_valid,
    output logic          evt_stall,
    input  sks_pkg::evt_t evt,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output sks_pkg::rsp_t rsp
);
    import sks_pkg::*;

    logic accept;
    logic full;
    rsp_t step_rsp;

    assign evt_stall = full;
    assign accept    = evt_valid && !full;

    sks_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .evt    (evt),
        .rsp    (step_rsp)
    );

    sks_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .din       (step_rsp),
        .full      (full),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

/* sv/sks_core.sv */
// ----------------------------------------------------------------------------
// sks_core: transfer phase, held scancode and full flag
// Decodes one accepted event transaction per cycle and forms its response.
// ----------------------------------------------------------------------------
module sks_core
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  sks_pkg::evt_t evt,
    output sks_pkg::rsp_t rsp
);
    import sks_pkg::*;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [7:0] held_code_reg;
    logic [7:0] held_code_next;
    logic       waiting_reg;
    logic       waiting_next;
    logic [7:0] miso;
    logic       miso_valid;
    logic [6:0] cmd;

    assign cmd = evt.mosi_byte[6:0];

    always_comb
    begin
        phase_next     = phase_reg;
        held_code_next = held_code_reg;
        waiting_next   = waiting_reg;
        miso           = RSP_ZERO;
        miso_valid     = 1'b0;
        unique case (evt.op)
            OP_SELECT:
            begin
                phase_next = PH_NEW;
            end
            OP_DESELECT:
            begin
                phase_next = PH_IDLE;
            end
            OP_BYTE:
            begin
                miso_valid = 1'b1;
                unique case (phase_reg)
                    PH_NEW:
                    begin
                        if (evt.mosi_byte[7])
                        begin
                            phase_next = PH_RESPOND;
                            if (cmd == CMD_RESET)
                            begin
                                phase_next     = PH_IDLE;
                                held_code_next = RSP_ZERO;
                                waiting_next   = 1'b0;
                            end
                            else if (cmd == CMD_STATUS)
                            begin
                                miso = waiting_reg ? RSP_ZERO : RSP_EMPTY;
                            end
                        end
                        else
                        begin
                            phase_next     = PH_READ;
                            miso           = held_code_reg;
                            held_code_next = RSP_ZERO;
                            waiting_next   = 1'b0;
                        end
                    end
                    PH_READ, PH_RESPOND:
                    begin
                        phase_next = PH_DONE;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
            OP_READY:
            begin
                if (evt.ready_level)
                begin
                    held_code_next = evt.scancode;
                    waiting_next   = 1'b1;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    assign rsp.miso_byte  = miso;
    assign rsp.miso_valid = miso_valid;
    assign rsp.irq        = waiting_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            held_code_reg <= 8'h00;
            waiting_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            held_code_reg <= held_code_next;
            waiting_reg   <= waiting_next;
        end
    end

    a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(phase_reg))
        else $error("phase register lost its one-hot code");

    a_empty_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !waiting_reg |-> (held_code_reg == 8'h00))
        else $error("held scancode nonzero while empty");

    a_ready_store: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && evt.op == OP_READY && evt.ready_level)
        |=> (waiting_reg && held_code_reg == $past(evt.scancode)))
        else $error("ready level did not store scancode");

    a_deselect: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && evt.op == OP_DESELECT) |=> (phase_reg == PH_IDLE))
        else $error("deselect did not return to idle");

endmodule

/* sv/sks_out_buf.sv */
// ----------------------------------------------------------------------------
// sks_out_buf: two-entry response buffer
// Registers responses and absorbs one transaction of output stall.
// ----------------------------------------------------------------------------
module sks_out_buf
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sks_pkg::rsp_t din,
    output logic          full,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output sks_pkg::rsp_t rsp
);
    import sks_pkg::*;

    rsp_t       slot0_reg;
    rsp_t       slot1_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;

    assign rsp_valid = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);
    assign pop       = rsp_valid && !rsp_stall;
    assign rsp       = slot0_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (count_reg == 2'd2)
            begin
                slot0_reg <= slot1_reg;
                if (push)
                begin
                    slot1_reg <= din;
                end
            end
            else if (push)
            begin
                slot0_reg <= din;
            end
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
            begin
                slot0_reg <= din;
            end
            else
            begin
                slot1_reg <= din;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

/* test/sks_response_checker.sv */
// ----------------------------------------------------------------------------
// sks_response_checker: response predictor and comparator for the scancode slave
// Watches both channels, predicts the response to every accepted event from
// its own copy of phase, held scancode and full flag, and compares each
// accepted response against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module sks_response_checker
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          evt_valid,
    input  logic          evt_stall,
    input  sks_pkg::evt_t evt,
    input  logic          rsp_valid,
    input  logic          rsp_stall,
    input  sks_pkg::rsp_t rsp,
    output int            failures,
    output int            pending
);
    import sks_pkg::*;

    phase_t     cur_phase;
    logic [7:0] held_code;
    logic       code_waiting;
    rsp_t       expected_rsp[$];
    rsp_t       want;
    int         mismatch_cnt;

    task automatic predict_response(input evt_t e, output rsp_t r);
        logic [7:0] out_byte;
        out_byte = RSP_ZERO;
        r = '0;
        case (e.op)
            OP_SELECT: cur_phase = PH_NEW;
            OP_DESELECT: cur_phase = PH_IDLE;
            OP_BYTE:
            begin
                r.miso_valid = 1'b1;
                case (cur_phase)
                    PH_NEW:
                    begin
                        if (e.mosi_byte[7])
                        begin
                            cur_phase = PH_RESPOND;
                            if (e.mosi_byte[6:0] == CMD_RESET)
                            begin
                                cur_phase    = PH_IDLE;
                                held_code    = '0;
                                code_waiting = 1'b0;
                            end
                            else if (e.mosi_byte[6:0] == CMD_STATUS)
                            begin
                                out_byte = code_waiting ? RSP_ZERO : RSP_EMPTY;
                            end
                        end
                        else
                        begin
                            cur_phase    = PH_READ;
                            out_byte     = held_code;
                            held_code    = '0;
                            code_waiting = 1'b0;
                        end
                    end
                    PH_READ, PH_RESPOND: cur_phase = PH_DONE;
                    default: ;
                endcase
            end
            default:
            begin
                if (e.ready_level)
                begin
                    held_code    = e.scancode;
                    code_waiting = 1'b1;
                end
            end
        endcase
        r.miso_byte = out_byte;
        r.irq       = code_waiting;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_phase    = PH_IDLE;
            held_code    = '0;
            code_waiting = 1'b0;
            expected_rsp.delete();
            mismatch_cnt = 0;
            failures    <= 0;
            pending     <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("tb: unexpected response miso_byte=%h miso_valid=%b irq=%b",
                                 rsp.miso_byte, rsp.miso_valid, rsp.irq);
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    if (want.miso_byte !== rsp.miso_byte || want.miso_valid !== rsp.miso_valid
                        || want.irq !== rsp.irq)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display({"tb: mismatch expected miso_byte=%h miso_valid=%b irq=%b",
                                      " got miso_byte=%h miso_valid=%b irq=%b"},
                                     want.miso_byte, want.miso_valid, want.irq,
                                     rsp.miso_byte, rsp.miso_valid, rsp.irq);
                    end
                end
            end
            if (evt_valid && !evt_stall)
            begin
                predict_response(evt, want);
                expected_rsp.push_back(want);
            end
            failures <= mismatch_cnt;
            pending  <= expected_rsp.size();
        end
    end

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the SPI keyboard scancode slave
// Drives a directed event list and then random SPI transfers mixed with
// keyboard ready events and noise, under changing idle patterns on both
// channels; the response checker predicts and compares every transaction.
// ----------------------------------------------------------------------------
module testbench;
    import sks_pkg::*;

    logic clk;
    logic rst_n;
    logic evt_valid;
    logic evt_stall;
    evt_t evt;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;
    int   failures;
    int   pending;
    int   sent_count;
    int   tx_idle_pct;
    int   rx_idle_pct;
    int   hold_len;
    int   hold_reqs;
    int   hold_seen;

    spi_keyboard_scancode_slave dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    sks_response_checker checker_i
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .failures  (failures),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(12 * 200000);
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        rsp_stall = 1'b0;
        hold_len  = 0;
        hold_seen = 0;
        forever
        begin
            @(posedge clk);
            if (hold_seen != hold_reqs)
            begin
                hold_seen = hold_reqs;
                rsp_stall <= 1'b1;
                hold_len  <= 80;
            end
            else if (hold_len > 0)
            begin
                rsp_stall <= 1'b1;
                hold_len  <= hold_len - 1;
            end
            else
            begin
                rsp_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    function automatic evt_t rand_event(input logic [1:0] op);
        evt_t e;
        e.op          = op;
        e.mosi_byte   = 8'($urandom_range(255));
        e.ready_level = 1'($urandom_range(1));
        e.scancode    = 8'($urandom_range(255));
        return e;
    endfunction

    function automatic evt_t byte_event(input logic [7:0] b);
        evt_t e;
        e           = rand_event(OP_BYTE);
        e.mosi_byte = b;
        return e;
    endfunction

    function automatic evt_t ready_event(input logic lvl, input logic [7:0] code);
        evt_t e;
        e             = rand_event(OP_READY);
        e.ready_level = lvl;
        e.scancode    = code;
        return e;
    endfunction

    task automatic send_event(input evt_t e);
        evt       <= e;
        evt_valid <= 1'b1;
        @(posedge clk);
        while (evt_stall)
            @(posedge clk);
        sent_count++;
        if ($urandom_range(99) < tx_idle_pct)
        begin
            evt_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < tx_idle_pct)
                @(posedge clk);
        end
    endtask

    task automatic drain;
        evt_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic maybe_ready;
        if ($urandom_range(4) == 0)
            send_event(ready_event(1'($urandom_range(3) != 0), 8'($urandom_range(255))));
    endtask

    task automatic send_transfer;
        logic [7:0] first;
        int         extra;
        case ($urandom_range(9))
            0, 1, 2, 3: first = {1'b0, 7'($urandom_range(127))};
            4:          first = {1'b1, CMD_RESET};
            5, 6, 7:    first = {1'b1, CMD_STATUS};
            default:    first = {1'b1, 7'($urandom_range(127))};
        endcase
        maybe_ready();
        send_event(rand_event(OP_SELECT));
        maybe_ready();
        send_event(byte_event(first));
        if ($urandom_range(4) != 0)
        begin
            maybe_ready();
            send_event(byte_event(8'($urandom_range(255))));
        end
        extra = $urandom_range(2);
        repeat (extra)
            send_event(byte_event(8'($urandom_range(255))));
        maybe_ready();
        if ($urandom_range(6) != 0)
            send_event(rand_event(OP_DESELECT));
    endtask

    task automatic random_events(input int target);
        int stop_at;
        stop_at = sent_count + target;
        while (sent_count < stop_at)
        begin
            if ($urandom_range(99) < 80)
                send_transfer();
            else
                send_event(rand_event(2'($urandom_range(3))));
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        evt_valid   = 1'b0;
        evt         = '0;
        sent_count  = 0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_reqs   = 0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_event(byte_event(8'h00));
        send_event(ready_event(1'b0, 8'hAA));
        send_event(ready_event(1'b1, 8'hFF));
        send_event(rand_event(OP_SELECT));
        send_event(byte_event(8'h00));
        send_event(byte_event(8'hFF));
        send_event(byte_event(8'h80));
        send_event(rand_event(OP_DESELECT));
        send_event(rand_event(OP_SELECT));
        send_event(byte_event({1'b1, CMD_STATUS}));
        send_event(ready_event(1'b1, 8'h00));
        send_event(rand_event(OP_SELECT));
        send_event(byte_event({1'b1, CMD_STATUS}));
        send_event(byte_event(8'h7F));
        send_event(rand_event(OP_SELECT));
        send_event(byte_event({1'b1, CMD_RESET}));
        send_event(byte_event(8'h55));
        send_event(rand_event(OP_SELECT));
        send_event(byte_event(8'hFF));
        send_event(byte_event(8'h00));
        send_event(rand_event(OP_SELECT));
        send_event(byte_event(8'h7F));
        send_event(rand_event(OP_DESELECT));
        send_event(byte_event(8'h01));
        drain();

        tx_idle_pct = 33;
        rx_idle_pct = 67;
        random_events(200);
        hold_reqs++;
        random_events(12);
        drain();
        random_events(200);

        tx_idle_pct = 67;
        rx_idle_pct = 33;
        random_events(400);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_events(400);

        drain();
        repeat (10)
            @(posedge clk);
        if (failures == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* files.f */
sv/sks_pkg.sv
sv/sks_core.sv
sv/sks_out_buf.sv
sv/spi_keyboard_scancode_slave.sv
test/sks_response_checker.sv
test/testbench.sv
